[rtl/lamport_mutex_node_defines.svh]
// Assertion macros shared by the Lamport mutual exclusion node.
`ifndef LAMPORT_MUTEX_NODE_DEFINES_SVH
`define LAMPORT_MUTEX_NODE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMN_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lmn_pkg.sv]
// Package with types and constants of the Lamport mutual exclusion node.
`default_nettype none
package lmn_pkg;

   localparam int MSG_STAMP_W    = 16;
   localparam int ID_W           = 4;
   localparam int NCOUNT_W       = 5;
   localparam int CSR_W          = 5;
   localparam int CSR_IDX_W      = 2;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_STAMP_BITS  = 16;

   // Opcodes of a request.
   localparam logic [2:0] OP_LOCAL_REQ = 3'd0;
   localparam logic [2:0] OP_LOCAL_REL = 3'd1;
   localparam logic [2:0] OP_RX_REQ    = 3'd2;
   localparam logic [2:0] OP_RX_REPLY  = 3'd3;
   localparam logic [2:0] OP_RX_REL    = 3'd4;
   localparam logic [2:0] OP_RX_DONE   = 3'd5;

   // Kinds of outgoing message.
   localparam logic [1:0] SEND_NONE    = 2'd0;
   localparam logic [1:0] SEND_REQ     = 2'd1;
   localparam logic [1:0] SEND_REL     = 2'd2;
   localparam logic [1:0] SEND_REPLY   = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_FULL     = 2'd1;
   localparam logic [1:0] ERR_NOT_HEAD = 2'd2;
   localparam logic [1:0] ERR_BAD_MSG  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ID     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKING    = 2'd2;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [ID_W-1:0]        sender_id;
      logic [MSG_STAMP_W-1:0] msg_stamp;
   } req_type;

   typedef struct packed {
      logic [1:0]             send_kind;
      logic [ID_W-1:0]        send_dest;
      logic [MSG_STAMP_W-1:0] send_stamp;
      logic                   granted;
      logic [1:0]             error_code;
      logic [MSG_STAMP_W-1:0] clock_now;
      logic [3:0]             done_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // Command broadcast along the queue chain; the stamp travels beside it.
   typedef struct packed {
      cell_op_type     op;
      logic [ID_W-1:0] node;
   } chain_ctl_type;

endpackage
`default_nettype wire

[rtl/lmn_cell.sv]
// One entry of the sorted request queue, linked to its two neighbors.
`default_nettype none
module lmn_cell #(
   parameter int STAMP_BITS = lmn_pkg::DEF_STAMP_BITS,
   parameter int CNT_W      = 5,
   parameter int INDEX      = 0
) (
   input  wire logic                      clock,
   input  wire lmn_pkg::chain_ctl_type    ctl,
   input  wire logic [STAMP_BITS-1:0]     ins_stamp,
   input  wire logic [CNT_W-1:0]          count,
   input  wire logic                      left_keep,
   input  wire logic [STAMP_BITS-1:0]     left_stamp,
   input  wire logic [lmn_pkg::ID_W-1:0]  left_node,
   input  wire logic [STAMP_BITS-1:0]     right_stamp,
   input  wire logic [lmn_pkg::ID_W-1:0]  right_node,
   output logic                           keep,
   output logic [STAMP_BITS-1:0]          stamp,
   output logic [lmn_pkg::ID_W-1:0]       node
);
   import lmn_pkg::*;

   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [ID_W-1:0]       node_ff, node_in;
   logic                  occupied;

   assign occupied = (count > CNT_W'(INDEX));

   // An occupied entry whose key sorts at or before the new key stays put;
   // equal keys keep the older entry first.
   assign keep = occupied &&
                 ((stamp_ff < ins_stamp) ||
                  ((stamp_ff == ins_stamp) && (node_ff <= ctl.node)));

   always_comb begin
      stamp_in = stamp_ff;
      node_in  = node_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  stamp_in = ins_stamp;
                  node_in  = ctl.node;
               end else begin
                  stamp_in = left_stamp;
                  node_in  = left_node;
               end
            end
         end
         CELL_POP: begin
            stamp_in = right_stamp;
            node_in  = right_node;
         end
         default: begin
            stamp_in = stamp_ff;
            node_in  = node_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
      node_ff  <= node_in;
   end

   assign stamp = stamp_ff;
   assign node  = node_ff;

endmodule
`default_nettype wire

[rtl/lmn_queue.sv]
// Sorted request queue built as a row of linked cells.
`default_nettype none
module lmn_queue #(
   parameter int QUEUE_DEPTH = lmn_pkg::DEF_QUEUE_DEPTH,
   parameter int STAMP_BITS  = lmn_pkg::DEF_STAMP_BITS,
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                      clock,
   input  wire lmn_pkg::chain_ctl_type    ctl,
   input  wire logic [STAMP_BITS-1:0]     ins_stamp,
   input  wire logic [CNT_W-1:0]          count,
   output logic [lmn_pkg::ID_W-1:0]       head_node
);
   import lmn_pkg::*;

   logic                  cell_keep  [QUEUE_DEPTH];
   logic [STAMP_BITS-1:0] cell_stamp [QUEUE_DEPTH];
   logic [ID_W-1:0]       cell_node  [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == QUEUE_DEPTH - 1) ? i : i + 1;

      lmn_cell #(
         .STAMP_BITS (STAMP_BITS),
         .CNT_W      (CNT_W),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .ins_stamp   (ins_stamp),
         .count       (count),
         .left_keep   ((i == 0) ? 1'b1 : cell_keep[LEFT]),
         .left_stamp  (cell_stamp[LEFT]),
         .left_node   (cell_node[LEFT]),
         .right_stamp (cell_stamp[RIGHT]),
         .right_node  (cell_node[RIGHT]),
         .keep        (cell_keep[i]),
         .stamp       (cell_stamp[i]),
         .node        (cell_node[i])
      );
   end

   assign head_node = cell_node[0];

endmodule
`default_nettype wire

[rtl/lamport_mutex_node.sv]
// Top level of one Lamport mutual exclusion node.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/req_stall | lmn_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | lmn_pkg::rsp_type
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// After acceptance a request passes through the clock merge, one step of the queue
// cell chain, then the grant check on the new head, which loads the response.
// The next request is taken only once the node is back in its idle state.
// The response register holds a result while the next request is accepted.
// A stalled response delays the grant step until the register frees up.
// Reset is synchronous; it clears the clock and counters and restores the default configuration.
`default_nettype none
`include "lamport_mutex_node_defines.svh"
module lamport_mutex_node #(
   parameter int QUEUE_DEPTH = lmn_pkg::DEF_QUEUE_DEPTH,
   parameter int STAMP_BITS  = lmn_pkg::DEF_STAMP_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire lmn_pkg::req_type              req,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output lmn_pkg::rsp_type                   rsp,
   input  wire logic                          csr_we,
   input  wire logic [lmn_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lmn_pkg::CSR_W-1:0]     csr_wdata
);
   import lmn_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > NCOUNT_W) ? CNT_W : NCOUNT_W;
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLOCK,
      S_QUEUE,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Configuration.
   logic [ID_W-1:0]     own_id_ff, own_id_in;
   logic [NCOUNT_W-1:0] node_count_ff, node_count_in;
   logic                locking_ff, locking_in;

   // Protocol state.
   logic [STAMP_BITS-1:0] clock_ff, clock_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [4:0]            reply_ff, reply_in;
   logic                  waiting_ff, waiting_in;
   logic [3:0]            done_ff, done_in;

   // Request held during processing.
   logic [2:0]            op_ff, op_in;
   logic [ID_W-1:0]       sender_ff, sender_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;

   // Partial result carried into the grant step.
   logic [1:0]            kind_ff, kind_in;
   logic [ID_W-1:0]       dest_ff, dest_in;
   logic [STAMP_BITS-1:0] sstamp_ff, sstamp_in;
   logic [1:0]            err_ff, err_in;
   logic                  grant_now_ff, grant_now_in;
   logic                  grant_check_ff, grant_check_in;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   chain_ctl_type         chain_ctl;
   logic [STAMP_BITS-1:0] chain_stamp;
   logic [ID_W-1:0]       head_node;

   logic [NCOUNT_W-1:0]   capacity;
   logic [NCOUNT_W-1:0]   peers;
   logic                  queue_full;
   logic                  own_at_head;
   logic                  grant;
   logic                  fin_load;
   logic [STAMP_BITS-1:0] merged;

   lmn_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .STAMP_BITS  (STAMP_BITS),
      .CNT_W       (CNT_W)
   ) u_queue (
      .clock     (clock),
      .ctl       (chain_ctl),
      .ins_stamp (chain_stamp),
      .count     (count_ff),
      .head_node (head_node)
   );

   assign capacity    = (node_count_ff == '0) ? '0 : node_count_ff - 1'b1;
   assign peers       = (node_count_ff < NCOUNT_W'(2)) ? '0 : node_count_ff - NCOUNT_W'(2);
   assign queue_full  = (CMP_W'(count_ff) >= CMP_W'(capacity)) ||
                        (count_ff == CNT_W'(QUEUE_DEPTH));
   assign own_at_head = (count_ff != '0) && (head_node == own_id_ff);
   assign merged      = (stamp_ff > clock_ff) ? stamp_ff : clock_ff;

   assign grant    = grant_now_ff ||
                     (grant_check_ff && waiting_ff && (reply_ff == peers) && own_at_head);
   assign fin_load = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      own_id_in      = own_id_ff;
      node_count_in  = node_count_ff;
      locking_in     = locking_ff;
      clock_in       = clock_ff;
      count_in       = count_ff;
      reply_in       = reply_ff;
      waiting_in     = waiting_ff;
      done_in        = done_ff;
      op_in          = op_ff;
      sender_in      = sender_ff;
      stamp_in       = stamp_ff;
      kind_in        = kind_ff;
      dest_in        = dest_ff;
      sstamp_in      = sstamp_ff;
      err_in         = err_ff;
      grant_now_in   = grant_now_ff;
      grant_check_in = grant_check_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      chain_ctl.op   = CELL_HOLD;
      chain_ctl.node = own_id_ff;
      chain_stamp    = clock_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:     own_id_in     = csr_wdata[ID_W-1:0];
            CSR_NODE_COUNT: node_count_in = csr_wdata[NCOUNT_W-1:0];
            CSR_LOCKING:    locking_in    = csr_wdata[0];
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req.opcode;
               sender_in = req.sender_id;
               stamp_in  = STAMP_BITS'(req.msg_stamp);
               state_in  = S_CLOCK;
            end
         end
         S_CLOCK: begin
            // Received messages merge the stamp first; local ones tick only
            // when the protocol is running.
            if (op_ff >= OP_RX_REQ) begin
               clock_in = (merged == STAMP_MAX) ? merged : merged + 1'b1;
            end else if (locking_ff) begin
               clock_in = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + 1'b1;
            end
            state_in = S_QUEUE;
         end
         S_QUEUE: begin
            kind_in        = SEND_NONE;
            dest_in        = '0;
            sstamp_in      = '0;
            err_in         = ERR_NONE;
            grant_now_in   = 1'b0;
            grant_check_in = 1'b0;
            case (op_ff)
               OP_LOCAL_REQ: begin
                  if (!locking_ff) begin
                     grant_now_in = 1'b1;
                  end else if (queue_full) begin
                     err_in = ERR_FULL;
                  end else begin
                     chain_ctl.op   = CELL_INSERT;
                     chain_ctl.node = own_id_ff;
                     chain_stamp    = clock_ff;
                     count_in       = count_ff + 1'b1;
                     kind_in        = SEND_REQ;
                     sstamp_in      = clock_ff;
                     reply_in       = '0;
                     if (peers == '0) begin
                        grant_now_in = 1'b1;
                        waiting_in   = 1'b0;
                     end else begin
                        waiting_in   = 1'b1;
                     end
                  end
               end
               OP_LOCAL_REL: begin
                  if (locking_ff) begin
                     if (!own_at_head) begin
                        err_in = ERR_NOT_HEAD;
                     end else begin
                        chain_ctl.op = CELL_POP;
                        count_in     = count_ff - 1'b1;
                        kind_in      = SEND_REL;
                        sstamp_in    = clock_ff;
                        waiting_in   = 1'b0;
                     end
                  end
               end
               OP_RX_REQ: begin
                  if (queue_full) begin
                     err_in = ERR_FULL;
                  end else begin
                     chain_ctl.op   = CELL_INSERT;
                     chain_ctl.node = sender_ff;
                     chain_stamp    = stamp_ff;
                     count_in       = count_ff + 1'b1;
                     clock_in  = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + 1'b1;
                     sstamp_in = (clock_ff == STAMP_MAX) ? clock_ff : clock_ff + 1'b1;
                     kind_in   = SEND_REPLY;
                     dest_in   = sender_ff;
                  end
               end
               OP_RX_REPLY: begin
                  if (waiting_ff) begin
                     reply_in       = (reply_ff == '1) ? reply_ff : reply_ff + 1'b1;
                     grant_check_in = 1'b1;
                  end
               end
               OP_RX_REL: begin
                  if ((count_ff == '0) || (head_node != sender_ff)) begin
                     err_in = ERR_NOT_HEAD;
                  end else begin
                     chain_ctl.op   = CELL_POP;
                     count_in       = count_ff - 1'b1;
                     grant_check_in = 1'b1;
                  end
               end
               OP_RX_DONE: begin
                  done_in = (done_ff == '1) ? done_ff : done_ff + 1'b1;
               end
               default: begin
                  err_in = ERR_BAD_MSG;
               end
            endcase
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // The grant test sees the head after any pop of the previous step.
            if (fin_load) begin
               rsp_in.send_kind  = kind_ff;
               rsp_in.send_dest  = dest_ff;
               rsp_in.send_stamp = MSG_STAMP_W'(sstamp_ff);
               rsp_in.granted    = grant;
               rsp_in.error_code = err_ff;
               rsp_in.clock_now  = MSG_STAMP_W'(clock_ff);
               rsp_in.done_seen  = done_ff;
               rsp_valid_in      = 1'b1;
               // A grant without the grant check, as with locking off, leaves the waiting flag alone.
               if (grant_check_ff && grant) begin
                  waiting_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         own_id_ff     <= ID_W'(1);
         node_count_ff <= NCOUNT_W'(2);
         locking_ff    <= 1'b1;
         clock_ff      <= '0;
         count_ff      <= '0;
         reply_ff      <= '0;
         waiting_ff    <= 1'b0;
         done_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         own_id_ff     <= own_id_in;
         node_count_ff <= node_count_in;
         locking_ff    <= locking_in;
         clock_ff      <= clock_in;
         count_ff      <= count_in;
         reply_ff      <= reply_in;
         waiting_ff    <= waiting_in;
         done_ff       <= done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      sender_ff      <= sender_in;
      stamp_ff       <= stamp_in;
      kind_ff        <= kind_in;
      dest_ff        <= dest_in;
      sstamp_ff      <= sstamp_in;
      err_ff         <= err_in;
      grant_now_ff   <= grant_now_in;
      grant_check_ff <= grant_check_in;
      rsp_ff         <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `LMN_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
   `LMN_ASSERT_NEXT(a_count_only_in_queue_step, clock, reset, state_ff != S_QUEUE, $stable(count_ff), "queue count changed outside the queue step")
   `LMN_ASSERT_NEXT(a_clock_monotonic, clock, reset, 1'b1, clock_ff >= $past(clock_ff), "Lamport clock went backward")
   `LMN_ASSERT_HOLDS(a_grant_no_error, clock, reset, rsp_valid_ff && rsp_ff.granted, rsp_ff.error_code == ERR_NONE, "grant reported with an error")
   `LMN_ASSERT_NEXT(a_grant_clears_wait, clock, reset, fin_load && grant_check_ff && grant, !waiting_ff, "still waiting after a grant")

endmodule
`default_nettype wire

[tb/sv/lamport_node_checker.sv]
// Checker that predicts and compares every response of the Lamport mutex node.
module lamport_node_checker
   import lmn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   pending,
   output int                   queued,
   output logic [ID_W-1:0]      front_id,
   output int                   grant_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEF_QUEUE_DEPTH;
   localparam logic [MSG_STAMP_W-1:0] CLOCK_TOP = '1;

   logic [ID_W-1:0]        cfg_own;
   logic [NCOUNT_W-1:0]    cfg_nodes;
   logic                   cfg_lock;

   logic [MSG_STAMP_W-1:0] lclock;
   logic [MSG_STAMP_W-1:0] q_stamp [DEPTH];
   logic [ID_W-1:0]        q_node  [DEPTH];
   int                     q_fill;
   int                     replies;
   logic                   waiting;
   int                     dones;

   rsp_type                awaited_rsp [$];

   function automatic int peer_total();
      return (cfg_nodes >= 2) ? int'(cfg_nodes) - 2 : 0;
   endfunction

   function automatic int room();
      int c;
      c = (cfg_nodes >= 1) ? int'(cfg_nodes) - 1 : 0;
      return (c > DEPTH) ? DEPTH : c;
   endfunction

   function automatic void advance();
      if (lclock != CLOCK_TOP) lclock++;
   endfunction

   // Keeps the queue ordered by stamp, then node id; equal keys stay behind older ones.
   function automatic bit insert_sorted(logic [MSG_STAMP_W-1:0] stamp, logic [ID_W-1:0] node);
      int slot;
      if (q_fill >= room() || q_fill >= DEPTH) return 1'b0;
      slot = q_fill;
      while (slot > 0 && (q_stamp[slot-1] > stamp ||
                          (q_stamp[slot-1] == stamp && q_node[slot-1] > node))) begin
         q_stamp[slot] = q_stamp[slot-1];
         q_node[slot]  = q_node[slot-1];
         slot--;
      end
      q_stamp[slot] = stamp;
      q_node[slot]  = node;
      q_fill++;
      return 1'b1;
   endfunction

   function automatic bit pop_head(logic [ID_W-1:0] node);
      if (q_fill == 0 || q_node[0] != node) return 1'b0;
      for (int i = 1; i < q_fill; i++) begin
         q_stamp[i-1] = q_stamp[i];
         q_node[i-1]  = q_node[i];
      end
      q_fill--;
      return 1'b1;
   endfunction

   function automatic bit own_first();
      return q_fill > 0 && q_node[0] == cfg_own;
   endfunction

   function automatic rsp_type lamport_step(req_type r);
      rsp_type o;
      o = '0;
      // Every received message first merges its stamp into the clock.
      if (r.opcode >= OP_RX_REQ) begin
         if (r.msg_stamp > lclock) lclock = r.msg_stamp;
         advance();
      end
      case (r.opcode)
         OP_LOCAL_REQ: begin
            if (!cfg_lock) begin
               o.granted = 1'b1;
            end else begin
               advance();
               if (!insert_sorted(lclock, cfg_own)) begin
                  o.error_code = ERR_FULL;
               end else begin
                  o.send_kind  = SEND_REQ;
                  o.send_stamp = lclock;
                  replies = 0;
                  if (peer_total() == 0) begin
                     o.granted = 1'b1;
                     waiting   = 1'b0;
                  end else begin
                     waiting = 1'b1;
                  end
               end
            end
         end
         OP_LOCAL_REL: begin
            if (cfg_lock) begin
               advance();
               if (!pop_head(cfg_own)) begin
                  o.error_code = ERR_NOT_HEAD;
               end else begin
                  o.send_kind  = SEND_REL;
                  o.send_stamp = lclock;
                  waiting = 1'b0;
               end
            end
         end
         OP_RX_REQ: begin
            if (!insert_sorted(r.msg_stamp, r.sender_id)) begin
               o.error_code = ERR_FULL;
            end else begin
               advance();
               o.send_kind  = SEND_REPLY;
               o.send_dest  = r.sender_id;
               o.send_stamp = lclock;
            end
         end
         OP_RX_REPLY: begin
            if (waiting) begin
               if (replies < 31) replies++;
               if (replies == peer_total() && own_first()) begin
                  o.granted = 1'b1;
                  waiting   = 1'b0;
               end
            end
         end
         OP_RX_REL: begin
            if (!pop_head(r.sender_id)) begin
               o.error_code = ERR_NOT_HEAD;
            end else if (waiting && replies == peer_total() && own_first()) begin
               o.granted = 1'b1;
               waiting   = 1'b0;
            end
         end
         OP_RX_DONE: begin
            if (dones < 15) dones++;
         end
         default: begin
            o.error_code = ERR_BAD_MSG;
         end
      endcase
      o.clock_now = lclock;
      o.done_seen = dones[3:0];
      return o;
   endfunction

   function automatic string show(rsp_type r);
      return $sformatf("kind=%0d dest=%0d stamp=%0d grant=%0d err=%0d clock=%0d done=%0d",
                       r.send_kind, r.send_dest, r.send_stamp, r.granted, r.error_code,
                       r.clock_now, r.done_seen);
   endfunction

   function automatic bit same_result(rsp_type a, rsp_type b);
      return a.send_kind === b.send_kind && a.send_dest === b.send_dest &&
             a.send_stamp === b.send_stamp && a.granted === b.granted &&
             a.error_code === b.error_code && a.clock_now === b.clock_now &&
             a.done_seen === b.done_seen;
   endfunction

   function automatic void note_failure(string why, string want_text, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s: expected %s, got %s", $realtime, why, want_text, show(got));
   endfunction

   initial begin
      mismatches  = 0;
      grant_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_own   = 4'd1;
         cfg_nodes = 5'd2;
         cfg_lock  = 1'b1;
         lclock    = '0;
         q_fill    = 0;
         replies   = 0;
         waiting   = 1'b0;
         dones     = 0;
         awaited_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_ID:     cfg_own   = csr_wdata[ID_W-1:0];
               CSR_NODE_COUNT: cfg_nodes = csr_wdata[NCOUNT_W-1:0];
               CSR_LOCKING:    cfg_lock  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               note_failure("Response with no request outstanding", "nothing", rsp);
            end else begin
               want = awaited_rsp.pop_front();
               if (!same_result(want, rsp))
                  note_failure("Response mismatch", show(want), rsp);
               else if (want.granted)
                  grant_count++;
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(lamport_step(req));
      end
      pending  = awaited_rsp.size();
      queued   = q_fill;
      front_id = (q_fill != 0) ? q_node[0] : '0;
   end

endmodule

[tb/sv/testbench.sv]
// Top of the Lamport mutex node testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lmn_pkg::*;

   // Opcodes the node has no use for; both must be flagged as unexpected.
   localparam logic [2:0] OP_SPARE_LO  = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         PHASES        = 8;
   localparam int         PHASE_ITEMS   = 100;

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req       = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   int                   mismatches;
   int                   pending;
   int                   queued;
   logic [ID_W-1:0]      front_id;
   int                   grant_count;

   int                   sent       = 0;
   int                   burst_left = 0;
   int                   settings   = 0;
   int                   sessions   = 0;
   logic [ID_W-1:0]      cur_own    = 4'd1;
   logic [NCOUNT_W-1:0]  cur_nodes  = 5'd2;
   logic                 cur_lock   = 1'b1;

   lamport_mutex_node u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lamport_node_checker u_chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .pending     (pending),
      .queued      (queued),
      .front_id    (front_id),
      .grant_count (grant_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // The receiver alternates between free-flowing, patchy and mostly stalled stretches.
   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 200);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 9) < 3);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   // Stamps start small and climb with the run, so the clock reaches high values late.
   function automatic logic [MSG_STAMP_W-1:0] pick_stamp();
      int ceiling;
      ceiling = 64 + sent * 64;
      if (ceiling > 60000) ceiling = 60000;
      if ($urandom_range(0, 3) == 0) return '0;
      return MSG_STAMP_W'($urandom_range(0, ceiling));
   endfunction

   task automatic issue(input logic [2:0] op, input logic [ID_W-1:0] who,
                        input logic [MSG_STAMP_W-1:0] stamp);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req       <= '{opcode: op, sender_id: who, msg_stamp: stamp};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
      burst_left--;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   task automatic settle_all();
      if (burst_left != 0) begin
         req_valid  <= 1'b0;
         burst_left = 0;
      end
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_settings(input logic [ID_W-1:0] own, input logic [NCOUNT_W-1:0] nodes,
                                input logic lock);
      settle_all();
      csr_we    <= 1'b1;
      csr_index <= CSR_OWN_ID;
      csr_wdata <= CSR_W'(own);
      @(negedge clock);
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= CSR_W'(nodes);
      @(negedge clock);
      csr_index <= CSR_LOCKING;
      csr_wdata <= CSR_W'(lock);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_own   = own;
      cur_nodes = nodes;
      cur_lock  = lock;
      settings++;
   endtask

   // Releases heads until empty, a guard trips or our entry leads with locking off.
   task automatic drain_queue();
      int guard;
      guard = 0;
      while (queued != 0 && guard < 40) begin
         guard++;
         if (front_id != cur_own)
            issue(OP_RX_REL, front_id, pick_stamp());
         else if (cur_lock)
            issue(OP_LOCAL_REL, ID_W'($urandom), MSG_STAMP_W'($urandom));
         else
            break;
      end
   endtask

   // One round of the protocol: rivals queue up, we request, peers reply, all release.
   task automatic run_session();
      int open_slots;
      int ahead;
      int extra;
      sessions++;
      if (queued != 0 && $urandom_range(0, 1) == 1) drain_queue();
      open_slots = int'(cur_nodes) - 1 - queued;
      if (open_slots < 1) open_slots = 1;
      if ($urandom_range(0, 7) == 0)
         ahead = $urandom_range(0, open_slots + 1);
      else
         ahead = $urandom_range(0, open_slots - 1);
      repeat (ahead) issue(OP_RX_REQ, ID_W'($urandom_range(0, 15)), pick_stamp());
      issue(OP_LOCAL_REQ, ID_W'($urandom), MSG_STAMP_W'($urandom));
      // Now and then a flood of surplus replies drives the reply count to its limit.
      extra = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 36) : 0;
      repeat (int'(cur_nodes) - 2 + extra) begin
         if ($urandom_range(0, 5) == 0)
            issue(OP_RX_REQ, ID_W'($urandom_range(0, 15)), '0);
         else if ($urandom_range(0, 9) == 0)
            issue(OP_RX_DONE, ID_W'($urandom_range(0, 15)), pick_stamp());
         issue(OP_RX_REPLY, ID_W'($urandom_range(0, 15)), pick_stamp());
      end
      if ($urandom_range(0, 5) == 0)
         issue(OP_RX_REL, ID_W'($urandom_range(0, 15)), pick_stamp());
      drain_queue();
   endtask

   task automatic noise_item();
      issue(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, 15)), pick_stamp());
   endtask

   initial begin
      int goal;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: no peers and room for a single request.
      issue(OP_LOCAL_REQ, 4'h0, 16'h0000);
      issue(OP_RX_REQ, 4'hF, 16'd5);
      issue(OP_LOCAL_REQ, 4'hA, 16'hAAAA);
      issue(OP_RX_REL, 4'd3, 16'd0);
      issue(OP_LOCAL_REL, 4'hF, 16'hFFFF);
      issue(OP_LOCAL_REL, 4'h0, 16'h0000);
      issue(OP_RX_REPLY, 4'd2, 16'd7);
      issue(OP_RX_DONE, 4'd9, 16'd0);
      issue(OP_SPARE_LO, 4'd1, 16'd3);
      issue(OP_SPARE_HI, 4'd14, 16'd2);
      issue(OP_RX_REQ, 4'd0, 16'd0);
      issue(OP_RX_REL, 4'd0, 16'd0);

      // One peer: the grant waits for the rival ahead of us to release.
      load_settings(4'd7, 5'd3, 1'b1);
      issue(OP_RX_REQ, 4'd2, 16'd1);
      issue(OP_LOCAL_REQ, 4'h5, 16'h5555);
      issue(OP_RX_REPLY, 4'd2, 16'd0);
      issue(OP_LOCAL_REL, 4'h0, 16'h0000);
      issue(OP_RX_REL, 4'd2, 16'd0);
      issue(OP_LOCAL_REL, 4'h0, 16'h0000);

      // Locking off, with two rivals tied on stamp.
      load_settings(4'd15, 5'd16, 1'b0);
      issue(OP_LOCAL_REQ, 4'h3, 16'h1234);
      issue(OP_LOCAL_REL, 4'hC, 16'hEDCB);
      issue(OP_RX_REQ, 4'd15, 16'd9);
      issue(OP_RX_REQ, 4'd3, 16'd9);
      issue(OP_RX_REL, 4'd15, 16'd0);
      issue(OP_RX_REL, 4'd3, 16'd0);
      issue(OP_RX_REL, 4'd15, 16'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       load_settings(4'd15, 5'd16, 1'b1);
            1:       load_settings(4'd1, 5'd2, 1'b1);
            2:       load_settings(ID_W'($urandom_range(1, 15)),
                                   NCOUNT_W'($urandom_range(2, 16)), 1'b0);
            default: load_settings(ID_W'($urandom_range(1, 15)),
                                   NCOUNT_W'($urandom_range(2, 16)),
                                   $urandom_range(0, 5) != 0);
         endcase
         goal = sent + PHASE_ITEMS;
         while (sent < goal) begin
            if ($urandom_range(0, 9) < 7)
               run_session();
            else
               repeat ($urandom_range(1, 4)) noise_item();
         end
      end

      // Finally push the clock into saturation and keep the protocol running there.
      load_settings(ID_W'($urandom_range(1, 15)), 5'd16, 1'b1);
      issue(OP_RX_REQ, ID_W'($urandom_range(0, 15)), 16'hFFFE);
      issue(OP_RX_DONE, ID_W'($urandom_range(0, 15)), 16'hFFFF);
      run_session();
      repeat (6) issue(3'($urandom_range(0, 7)), ID_W'($urandom_range(0, 15)),
                       MSG_STAMP_W'($urandom));
      drain_queue();

      settle_all();
      $display("Run covered %0d requests in %0d register settings and %0d protocol rounds.",
               sent, settings, sessions);
      $display("Responses with a grant checked: %0d.", grant_count);
      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
